// File: hdl/touch_sample_calibrate_scale_defines.svh
// Assertion macros shared by the touch sample calibration block.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef TOUCH_SAMPLE_CALIBRATE_SCALE_DEFINES_SVH
`define TOUCH_SAMPLE_CALIBRATE_SCALE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tscs_pkg.sv
// Package for the touch sample calibration block: widths, register map,
// status codes and the structs passed between its modules. No dependencies.
package tscs_pkg;

    localparam int CFG_W  = 10;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int PAD_W  = DATA_W - CFG_W;
    localparam int OFS_W  = CFG_W + 1;

    localparam int X_SHIFT   = 7;
    localparam int Y_SHIFT   = 6;
    localparam int DIV_NUM_W = CFG_W + X_SHIFT;
    localparam int DIV_DEN_W = CFG_W;
    localparam int X_PIX_W   = 7;
    localparam int Y_PIX_W   = 6;

    localparam logic [2:0] REG_PRESS_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_JUMP_LIMIT      = 3'd1;
    localparam logic [2:0] REG_X_LOW_CAL       = 3'd2;
    localparam logic [2:0] REG_X_HIGH_CAL      = 3'd3;
    localparam logic [2:0] REG_Y_LOW_CAL       = 3'd4;
    localparam logic [2:0] REG_Y_HIGH_CAL      = 3'd5;

    localparam logic [CFG_W-1:0] RST_PRESS_THRESHOLD = 10'd900;
    localparam logic [CFG_W-1:0] RST_JUMP_LIMIT      = 10'd50;
    localparam logic [CFG_W-1:0] RST_X_LOW_CAL       = 10'd0;
    localparam logic [CFG_W-1:0] RST_X_HIGH_CAL      = 10'd1023;
    localparam logic [CFG_W-1:0] RST_Y_LOW_CAL       = 10'd0;
    localparam logic [CFG_W-1:0] RST_Y_HIGH_CAL      = 10'd1023;

    localparam logic [1:0] ST_NO_PRESS  = 2'd0;
    localparam logic [1:0] ST_JUMP      = 2'd1;
    localparam logic [1:0] ST_OFFSCREEN = 2'd2;
    localparam logic [1:0] ST_ACCEPTED  = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] press_threshold;
        logic [CFG_W-1:0] jump_limit;
        logic [CFG_W-1:0] x_low_cal;
        logic [CFG_W-1:0] x_high_cal;
        logic [CFG_W-1:0] y_low_cal;
        logic [CFG_W-1:0] y_high_cal;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

// File: hdl/touch_sample_calibrate_scale.sv
// Top level of the touch sample calibration block: sequencer, offset and jump
// check, and output register. Uses tscs_pkg, tscs_regs, tscs_div and the defines header.
//
//   channel  direction  handshake                 payload
//   input    in         i_in_valid / o_in_stall   press_first, press_second, x_raw, y_raw
//   output   out        o_out_valid / i_out_stall status, x_pixel, y_pixel
//   config   in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Input is taken only in the idle state: an item passes the check, the X and Y divisions
// and the output state before the next input transfer; one that ends at the press, jump or
// range check skips both divisions, and one whose column overflows skips the Y division.
// The single divider yields one quotient bit per cycle, a 17-bit quotient per axis, X then Y.
// Reset is synchronous and returns the registers and stored offsets to their defaults.
// A stalled result holds the sequencer in its final state until the output register frees.
`include "touch_sample_calibrate_scale_defines.svh"

module touch_sample_calibrate_scale (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [tscs_pkg::CFG_W-1:0]   i_press_first,
    input  logic [tscs_pkg::CFG_W-1:0]   i_press_second,
    input  logic [tscs_pkg::CFG_W-1:0]   i_x_raw,
    input  logic [tscs_pkg::CFG_W-1:0]   i_y_raw,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_status,
    output logic [tscs_pkg::X_PIX_W-1:0] o_x_pixel,
    output logic [tscs_pkg::Y_PIX_W-1:0] o_y_pixel,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tscs_pkg::ADDR_W-1:0]  paddr,
    input  logic [tscs_pkg::DATA_W-1:0]  pwdata,
    output logic [tscs_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIVX  = 3'd2;
    localparam logic [2:0] S_DIVY  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam int OW = tscs_pkg::OFS_W;
    localparam int CW = tscs_pkg::CFG_W;
    localparam int NW = tscs_pkg::DIV_NUM_W;
    localparam int XW = tscs_pkg::X_PIX_W;
    localparam int YW = tscs_pkg::Y_PIX_W;
    localparam logic [NW-1:0] Q_ROWS = NW'(1 << tscs_pkg::Y_SHIFT);
    localparam logic [XW-1:0] ROWS   = XW'(1 << tscs_pkg::Y_SHIFT);

    tscs_pkg::t_cfg     w_cfg;
    tscs_pkg::t_div_req w_div_req;
    tscs_pkg::t_div_rsp w_div_rsp;

    logic [2:0]    r_state;
    logic [CW-1:0] r_p1;
    logic [CW-1:0] r_p2;
    logic [CW-1:0] r_xr;
    logic [CW-1:0] r_yr;
    logic [OW-1:0] r_last_x;
    logic [OW-1:0] r_last_y;
    logic [CW-1:0] r_yo;
    logic [CW-1:0] r_ys;
    logic [XW-1:0] r_col;
    logic [1:0]    r_res_status;
    logic [XW-1:0] r_res_x;
    logic [YW-1:0] r_res_y;
    logic          r_out_valid;
    logic [1:0]    r_out_status;
    logic [XW-1:0] r_out_x;
    logic [YW-1:0] r_out_y;

    logic          w_in_xfer;
    logic          w_out_load;
    logic          w_press;
    logic [OW-1:0] w_xo;
    logic [OW-1:0] w_yo;
    logic [OW-1:0] w_xs;
    logic [OW-1:0] w_ys;
    logic [OW:0]   w_dx;
    logic [OW:0]   w_dy;
    logic [OW:0]   w_adx;
    logic [OW:0]   w_ady;
    logic          w_jump;
    logic          w_bad;
    logic          w_col_ok;
    logic          w_q_ok;
    logic [XW-1:0] w_row;

    tscs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tscs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    assign w_press = (r_p1 > w_cfg.press_threshold) && (r_p2 > w_cfg.press_threshold);
    assign w_xo    = {1'b0, r_xr} - {1'b0, w_cfg.x_low_cal};
    assign w_yo    = {1'b0, r_yr} - {1'b0, w_cfg.y_low_cal};
    assign w_xs    = {1'b0, w_cfg.x_high_cal} - {1'b0, w_cfg.x_low_cal};
    assign w_ys    = {1'b0, w_cfg.y_high_cal} - {1'b0, w_cfg.y_low_cal};

    assign w_dx   = {w_xo[OW-1], w_xo} - {r_last_x[OW-1], r_last_x};
    assign w_dy   = {w_yo[OW-1], w_yo} - {r_last_y[OW-1], r_last_y};
    assign w_adx  = w_dx[OW] ? ((OW+1)'(0) - w_dx) : w_dx;
    assign w_ady  = w_dy[OW] ? ((OW+1)'(0) - w_dy) : w_dy;
    assign w_jump = (w_adx > {2'b00, w_cfg.jump_limit}) ||
                    (w_ady > {2'b00, w_cfg.jump_limit});

    assign w_bad = w_xo[OW-1] || w_yo[OW-1] || w_xs[OW-1] || (w_xs == '0) ||
                   w_ys[OW-1] || (w_ys == '0);

    assign w_col_ok = (w_div_rsp.quotient[NW-1:XW] == '0);
    assign w_q_ok   = (w_div_rsp.quotient != '0) && (w_div_rsp.quotient <= Q_ROWS);
    assign w_row    = ROWS - w_div_rsp.quotient[XW-1:0];

    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = {w_xo[CW-1:0], {tscs_pkg::X_SHIFT{1'b0}}};
        w_div_req.divisor  = w_xs[CW-1:0];
        if (r_state == S_CHECK) begin
            w_div_req.start = w_press && !w_jump && !w_bad;
        end else if (r_state == S_DIVX) begin
            w_div_req.start    = w_div_rsp.done && w_col_ok;
            w_div_req.dividend = NW'({r_yo, {tscs_pkg::Y_SHIFT{1'b0}}});
            w_div_req.divisor  = r_ys;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_press) begin
                        r_last_x <= w_xo;
                        r_last_y <= w_yo;
                    end
                    r_state <= w_div_req.start ? S_DIVX : S_OUT;
                end
                S_DIVX: begin
                    if (w_div_rsp.done) begin
                        r_state <= w_col_ok ? S_DIVY : S_OUT;
                    end
                end
                S_DIVY: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_p1 <= i_press_first;
            r_p2 <= i_press_second;
            r_xr <= i_x_raw;
            r_yr <= i_y_raw;
        end
        if (r_state == S_CHECK) begin
            r_yo    <= w_yo[CW-1:0];
            r_ys    <= w_ys[CW-1:0];
            r_res_x <= '0;
            r_res_y <= '0;
            priority if (!w_press) begin
                r_res_status <= tscs_pkg::ST_NO_PRESS;
            end else if (w_jump) begin
                r_res_status <= tscs_pkg::ST_JUMP;
            end else begin
                r_res_status <= tscs_pkg::ST_OFFSCREEN;
            end
        end
        if ((r_state == S_DIVX) && w_div_rsp.done) begin
            r_col <= w_div_rsp.quotient[XW-1:0];
        end
        if ((r_state == S_DIVY) && w_div_rsp.done && w_q_ok) begin
            r_res_status <= tscs_pkg::ST_ACCEPTED;
            r_res_x      <= r_col;
            r_res_y      <= w_row[YW-1:0];
        end
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_x      <= r_res_x;
            r_out_y      <= r_res_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_x_pixel   = r_out_x;
    assign o_y_pixel   = r_out_y;

    `TSCS_ASSERT_NEXT(a_accept_to_check, i_clk, i_rst_n, w_in_xfer, r_state == S_CHECK, "transfer did not start the check step")
    `TSCS_ASSERT_NOW(a_div_done_in_div, i_clk, i_rst_n, w_div_rsp.done, (r_state == S_DIVX) || (r_state == S_DIVY), "divider finished outside a divide state")
    `TSCS_ASSERT_NOW(a_pixels_zero, i_clk, i_rst_n, o_out_valid && (o_status != tscs_pkg::ST_ACCEPTED), (o_x_pixel == '0) && (o_y_pixel == '0), "pixels not zero on a rejected result")
    `TSCS_ASSERT_NOW(a_load_from_out, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_OUT, "result loaded outside the output state")

endmodule

// File: hdl/tscs_regs.sv
// Configuration register file with an APB-style write and read port.
// Depends on tscs_pkg for the register map, reset values and t_cfg.
module tscs_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tscs_pkg::ADDR_W-1:0] paddr,
    input  logic [tscs_pkg::DATA_W-1:0] pwdata,
    output logic [tscs_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output tscs_pkg::t_cfg              o_cfg
);

    tscs_pkg::t_cfg              r_cfg;
    logic [2:0]                  w_idx;
    logic                        w_wr;
    logic [tscs_pkg::CFG_W-1:0]  w_wdata;
    logic [tscs_pkg::CFG_W-1:0]  w_rval;

    assign w_idx   = paddr[tscs_pkg::ADDR_W-1:2];
    assign w_wr    = psel && penable && pwrite;
    assign w_wdata = pwdata[tscs_pkg::CFG_W-1:0];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_threshold <= tscs_pkg::RST_PRESS_THRESHOLD;
            r_cfg.jump_limit      <= tscs_pkg::RST_JUMP_LIMIT;
            r_cfg.x_low_cal       <= tscs_pkg::RST_X_LOW_CAL;
            r_cfg.x_high_cal      <= tscs_pkg::RST_X_HIGH_CAL;
            r_cfg.y_low_cal       <= tscs_pkg::RST_Y_LOW_CAL;
            r_cfg.y_high_cal      <= tscs_pkg::RST_Y_HIGH_CAL;
        end else if (w_wr) begin
            unique case (w_idx)
                tscs_pkg::REG_PRESS_THRESHOLD: r_cfg.press_threshold <= w_wdata;
                tscs_pkg::REG_JUMP_LIMIT:      r_cfg.jump_limit      <= w_wdata;
                tscs_pkg::REG_X_LOW_CAL:       r_cfg.x_low_cal       <= w_wdata;
                tscs_pkg::REG_X_HIGH_CAL:      r_cfg.x_high_cal      <= w_wdata;
                tscs_pkg::REG_Y_LOW_CAL:       r_cfg.y_low_cal       <= w_wdata;
                tscs_pkg::REG_Y_HIGH_CAL:      r_cfg.y_high_cal      <= w_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            tscs_pkg::REG_PRESS_THRESHOLD: w_rval = r_cfg.press_threshold;
            tscs_pkg::REG_JUMP_LIMIT:      w_rval = r_cfg.jump_limit;
            tscs_pkg::REG_X_LOW_CAL:       w_rval = r_cfg.x_low_cal;
            tscs_pkg::REG_X_HIGH_CAL:      w_rval = r_cfg.x_high_cal;
            tscs_pkg::REG_Y_LOW_CAL:       w_rval = r_cfg.y_low_cal;
            tscs_pkg::REG_Y_HIGH_CAL:      w_rval = r_cfg.y_high_cal;
            default:                       w_rval = '0;
        endcase
    end

    assign prdata = {{tscs_pkg::PAD_W{1'b0}}, w_rval};

endmodule

// File: hdl/tscs_div.sv
// Shared restoring divider: one quotient bit per cycle, one division at a time.
// Depends on tscs_pkg for the operand widths and the request/response structs.
module tscs_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tscs_pkg::t_div_req i_req,
    output tscs_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(tscs_pkg::DIV_NUM_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(tscs_pkg::DIV_NUM_W - 1);

    logic                             r_busy;
    logic                             r_done;
    logic [CNT_W-1:0]                 r_cnt;
    logic [tscs_pkg::DIV_DEN_W-1:0]   r_rem;
    logic [tscs_pkg::DIV_DEN_W-1:0]   r_den;
    logic [tscs_pkg::DIV_NUM_W-1:0]   r_quo;
    logic [tscs_pkg::DIV_DEN_W:0]     w_shift;
    logic [tscs_pkg::DIV_DEN_W:0]     w_diff;
    logic                             w_ge;

    assign w_shift = {r_rem, r_quo[tscs_pkg::DIV_NUM_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[tscs_pkg::DIV_DEN_W-1:0]
                          : w_shift[tscs_pkg::DIV_DEN_W-1:0];
            r_quo <= {r_quo[tscs_pkg::DIV_NUM_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: bench/touch_sample_checker.sv
`timescale 1ns / 100ps
// Checker for the touch sample calibration block: it watches the sample, result and
// register channels, predicts each result from its own copy of the settings and stored
// offsets, and compares. Depends on tscs_pkg.
module touch_sample_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic [tscs_pkg::CFG_W-1:0]    i_press_first,
    input  logic [tscs_pkg::CFG_W-1:0]    i_press_second,
    input  logic [tscs_pkg::CFG_W-1:0]    i_x_raw,
    input  logic [tscs_pkg::CFG_W-1:0]    i_y_raw,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [1:0]                    o_status,
    input  logic [tscs_pkg::X_PIX_W-1:0]  o_x_pixel,
    input  logic [tscs_pkg::Y_PIX_W-1:0]  o_y_pixel,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tscs_pkg::ADDR_W-1:0]   paddr,
    input  logic [tscs_pkg::DATA_W-1:0]   pwdata,
    input  logic [tscs_pkg::DATA_W-1:0]   prdata,
    input  logic                          pready,
    output int                            fail_count,
    output int                            pending
);

    typedef struct packed {
        logic [1:0]                   status;
        logic [tscs_pkg::X_PIX_W-1:0] x_pixel;
        logic [tscs_pkg::Y_PIX_W-1:0] y_pixel;
    } t_touch_result;

    logic [tscs_pkg::CFG_W-1:0]        setting [6];
    logic signed [tscs_pkg::OFS_W-1:0] prev_x_offset;
    logic signed [tscs_pkg::OFS_W-1:0] prev_y_offset;
    t_touch_result                     expected_touches [$];
    int                                errors = 0;

    function automatic int offset_change(input int now_ofs, input int prev_ofs);
        return (now_ofs > prev_ofs) ? now_ofs - prev_ofs : prev_ofs - now_ofs;
    endfunction

    function automatic t_touch_result calibrate_sample(
        input logic [tscs_pkg::CFG_W-1:0] press_a,
        input logic [tscs_pkg::CFG_W-1:0] press_b,
        input logic [tscs_pkg::CFG_W-1:0] x_reading,
        input logic [tscs_pkg::CFG_W-1:0] y_reading
    );
        int            x_ofs;
        int            y_ofs;
        int            x_span;
        int            y_span;
        int            column;
        int            y_steps;
        int            row;
        int            limit;
        logic          jumped;
        t_touch_result res;
        res = '0;
        res.status = tscs_pkg::ST_NO_PRESS;
        if (press_a <= setting[tscs_pkg::REG_PRESS_THRESHOLD]
                || press_b <= setting[tscs_pkg::REG_PRESS_THRESHOLD])
            return res;
        x_ofs = int'(x_reading) - int'(setting[tscs_pkg::REG_X_LOW_CAL]);
        y_ofs = int'(y_reading) - int'(setting[tscs_pkg::REG_Y_LOW_CAL]);
        limit = int'(setting[tscs_pkg::REG_JUMP_LIMIT]);
        jumped = offset_change(x_ofs, int'(prev_x_offset)) > limit
              || offset_change(y_ofs, int'(prev_y_offset)) > limit;
        prev_x_offset = x_ofs[tscs_pkg::OFS_W-1:0];
        prev_y_offset = y_ofs[tscs_pkg::OFS_W-1:0];
        if (jumped) begin
            res.status = tscs_pkg::ST_JUMP;
            return res;
        end
        x_span = int'(setting[tscs_pkg::REG_X_HIGH_CAL]) - int'(setting[tscs_pkg::REG_X_LOW_CAL]);
        y_span = int'(setting[tscs_pkg::REG_Y_HIGH_CAL]) - int'(setting[tscs_pkg::REG_Y_LOW_CAL]);
        res.status = tscs_pkg::ST_OFFSCREEN;
        if (x_ofs < 0 || y_ofs < 0 || x_span <= 0 || y_span <= 0)
            return res;
        column  = (x_ofs * (1 << tscs_pkg::X_SHIFT)) / x_span;
        y_steps = (y_ofs * (1 << tscs_pkg::Y_SHIFT)) / y_span;
        if (column > (1 << tscs_pkg::X_SHIFT) - 1 || y_steps < 1
                || y_steps > (1 << tscs_pkg::Y_SHIFT))
            return res;
        row = (1 << tscs_pkg::Y_SHIFT) - y_steps;
        res.status  = tscs_pkg::ST_ACCEPTED;
        res.x_pixel = column[tscs_pkg::X_PIX_W-1:0];
        res.y_pixel = row[tscs_pkg::Y_PIX_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_touch_result    want;
        logic [2:0]       index;
        index = paddr[tscs_pkg::ADDR_W-1:2];
        if (!i_rst_n) begin
            setting[tscs_pkg::REG_PRESS_THRESHOLD] = tscs_pkg::RST_PRESS_THRESHOLD;
            setting[tscs_pkg::REG_JUMP_LIMIT]      = tscs_pkg::RST_JUMP_LIMIT;
            setting[tscs_pkg::REG_X_LOW_CAL]       = tscs_pkg::RST_X_LOW_CAL;
            setting[tscs_pkg::REG_X_HIGH_CAL]      = tscs_pkg::RST_X_HIGH_CAL;
            setting[tscs_pkg::REG_Y_LOW_CAL]       = tscs_pkg::RST_Y_LOW_CAL;
            setting[tscs_pkg::REG_Y_HIGH_CAL]      = tscs_pkg::RST_Y_HIGH_CAL;
            prev_x_offset = '0;
            prev_y_offset = '0;
            expected_touches.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    setting[index] = pwdata[tscs_pkg::CFG_W-1:0];
                end else if (prdata !== {{tscs_pkg::PAD_W{1'b0}}, setting[index]}) begin
                    $error("prdata of register %0d: expected %0h, got %0h",
                           index, setting[index], prdata);
                    errors++;
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_touches.size() == 0) begin
                    $error("result transfer with no sample waiting: status %0d", o_status);
                    errors++;
                end else begin
                    want = expected_touches.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        errors++;
                    end
                    if (o_x_pixel !== want.x_pixel) begin
                        $error("x_pixel: expected %0d, got %0d", want.x_pixel, o_x_pixel);
                        errors++;
                    end
                    if (o_y_pixel !== want.y_pixel) begin
                        $error("y_pixel: expected %0d, got %0d", want.y_pixel, o_y_pixel);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall)
                expected_touches.push_back(
                    calibrate_sample(i_press_first, i_press_second, i_x_raw, i_y_raw));
        end
        fail_count <= errors;
        pending    <= expected_touches.size();
    end

endmodule

// File: bench/touch_sample_calibrate_scale_test.sv
`timescale 1ns / 100ps
// Top of the touch sample calibration testbench: clock, reset, register programming,
// touch stroke stimulus, output stalls and the verdict.
// Depends on tscs_pkg, touch_sample_calibrate_scale and touch_sample_checker.
module touch_sample_calibrate_scale_test;

    localparam int QUIET_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 48;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_ITEMS     = 125;
    localparam int PHASES          = 9;
    localparam int CALM_PHASE      = 0;
    localparam int SQUEEZE_PHASE   = 5;
    localparam int IDLE_PERCENT    = 14;
    localparam int MAX_READING     = (1 << tscs_pkg::CFG_W) - 1;

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         i_in_valid     = 1'b0;
    logic [tscs_pkg::CFG_W-1:0]   i_press_first  = '0;
    logic [tscs_pkg::CFG_W-1:0]   i_press_second = '0;
    logic [tscs_pkg::CFG_W-1:0]   i_x_raw        = '0;
    logic [tscs_pkg::CFG_W-1:0]   i_y_raw        = '0;
    logic                         i_out_stall    = 1'b0;
    logic                         psel           = 1'b0;
    logic                         penable        = 1'b0;
    logic                         pwrite         = 1'b0;
    logic [tscs_pkg::ADDR_W-1:0]  paddr          = '0;
    logic [tscs_pkg::DATA_W-1:0]  pwdata         = '0;
    logic                         o_in_stall;
    logic                         o_out_valid;
    logic [1:0]                   o_status;
    logic [tscs_pkg::X_PIX_W-1:0] o_x_pixel;
    logic [tscs_pkg::Y_PIX_W-1:0] o_y_pixel;
    logic [tscs_pkg::DATA_W-1:0]  prdata;
    logic                         pready;

    int fail_count;
    int pending;
    int quiet = 0;
    bit calm = 1'b0;
    bit squeeze = 1'b0;
    int reg_setting [6];
    int last_x = 0;
    int last_y = 0;

    touch_sample_calibrate_scale u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_press_first  (i_press_first),
        .i_press_second (i_press_second),
        .i_x_raw        (i_x_raw),
        .i_y_raw        (i_y_raw),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_x_pixel      (o_x_pixel),
        .o_y_pixel      (o_y_pixel),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    touch_sample_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_press_first  (i_press_first),
        .i_press_second (i_press_second),
        .i_x_raw        (i_x_raw),
        .i_y_raw        (i_y_raw),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_x_pixel      (o_x_pixel),
        .o_y_pixel      (o_y_pixel),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            quiet = 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("** touch_sample_calibrate_scale: FAILED **");
            $finish;
        end else begin
            quiet++;
        end
    end

    initial begin
        int hold;
        bit squeezed;
        hold = 0;
        squeezed = 1'b0;
        forever begin
            @(posedge i_clk);
            if (squeeze && !squeezed) begin
                squeezed = 1'b1;
                hold = HOLD_OFF_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    task automatic apb_access(input logic write_en, input logic [2:0] index, input int value);
        logic ready;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= {index, 2'b00};
        pwdata  <= tscs_pkg::DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            ready = pready;
            @(posedge i_clk);
        end while (!ready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic choose_settings(input int phase);
        int x_low;
        int y_low;
        case (phase)
            0: reg_setting = '{512, 40, 100, 900, 120, 880};
            1: reg_setting = '{0, MAX_READING, 0, MAX_READING, 0, MAX_READING};
            2: reg_setting = '{MAX_READING, 0, MAX_READING, 0, MAX_READING, 0};
            3: reg_setting = '{300, 30, 500, 500, 200, 100};
            4: reg_setting = '{700, 0, 10, 20, 0, 1};
            5: reg_setting = '{850, 25, 40, 1000, 60, 990};
            default: begin
                x_low = $urandom_range(0, 400);
                y_low = $urandom_range(0, 400);
                reg_setting[tscs_pkg::REG_PRESS_THRESHOLD] = $urandom_range(0, 1000);
                reg_setting[tscs_pkg::REG_JUMP_LIMIT] = ($urandom_range(3) == 0)
                    ? $urandom_range(0, MAX_READING) : $urandom_range(0, 80);
                reg_setting[tscs_pkg::REG_X_LOW_CAL]  = x_low;
                reg_setting[tscs_pkg::REG_X_HIGH_CAL] = $urandom_range(x_low, MAX_READING);
                reg_setting[tscs_pkg::REG_Y_LOW_CAL]  = y_low;
                reg_setting[tscs_pkg::REG_Y_HIGH_CAL] = $urandom_range(y_low, MAX_READING);
            end
        endcase
    endtask

    task automatic program_registers();
        for (int r = 0; r < 6; r++)
            apb_access(1'b1, 3'(r), reg_setting[r]);
        for (int r = 0; r < 6; r++)
            apb_access(1'b0, 3'(r), 0);
    endtask

    task automatic send_touch(input int press_a, input int press_b, input int x, input int y);
        logic taken;
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_press_first  <= tscs_pkg::CFG_W'(press_a);
        i_press_second <= tscs_pkg::CFG_W'(press_b);
        i_x_raw        <= tscs_pkg::CFG_W'(x);
        i_y_raw        <= tscs_pkg::CFG_W'(y);
        if (press_a > reg_setting[tscs_pkg::REG_PRESS_THRESHOLD]
                && press_b > reg_setting[tscs_pkg::REG_PRESS_THRESHOLD]) begin
            last_x = x;
            last_y = y;
        end
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    function automatic int press_level(input bit down);
        int thr;
        thr = reg_setting[tscs_pkg::REG_PRESS_THRESHOLD];
        if (down) begin
            if (thr >= MAX_READING)
                return MAX_READING;
            return ($urandom_range(9) == 0) ? thr + 1 : $urandom_range(thr + 1, MAX_READING);
        end
        return ($urandom_range(9) == 0) ? thr : $urandom_range(0, thr);
    endfunction

    function automatic int clamp_reading(input int value);
        return (value < 0) ? 0 : (value > MAX_READING) ? MAX_READING : value;
    endfunction

    task automatic random_touch();
        int kind;
        int reach;
        int x;
        int y;
        int press_a;
        int press_b;
        kind = $urandom_range(99);
        press_a = press_level(1'b1);
        press_b = press_level(1'b1);
        if (kind < 70) begin
            reach = reg_setting[tscs_pkg::REG_JUMP_LIMIT] + ($urandom_range(9) == 0);
            x = clamp_reading(last_x + int'($urandom_range(2 * reach)) - reach);
            y = clamp_reading(last_y + int'($urandom_range(2 * reach)) - reach);
        end else if (kind < 80) begin
            x = $urandom_range(reg_setting[tscs_pkg::REG_X_LOW_CAL],
                               reg_setting[tscs_pkg::REG_X_HIGH_CAL]);
            y = $urandom_range(reg_setting[tscs_pkg::REG_Y_LOW_CAL],
                               reg_setting[tscs_pkg::REG_Y_HIGH_CAL]);
        end else if (kind < 90) begin
            x = $urandom_range(0, MAX_READING);
            y = $urandom_range(0, MAX_READING);
            case ($urandom_range(2))
                0: press_a = press_level(1'b0);
                1: press_b = press_level(1'b0);
                default: begin
                    press_a = press_level(1'b0);
                    press_b = press_level(1'b0);
                end
            endcase
        end else begin
            press_a = $urandom_range(0, MAX_READING);
            press_b = $urandom_range(0, MAX_READING);
            x = $urandom_range(0, MAX_READING);
            y = $urandom_range(0, MAX_READING);
        end
        send_touch(press_a, press_b, x, y);
    endtask

    task automatic finish_phase();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        reg_setting = '{tscs_pkg::RST_PRESS_THRESHOLD, tscs_pkg::RST_JUMP_LIMIT,
                        tscs_pkg::RST_X_LOW_CAL, tscs_pkg::RST_X_HIGH_CAL,
                        tscs_pkg::RST_Y_LOW_CAL, tscs_pkg::RST_Y_HIGH_CAL};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_touch(0, 0, 0, 0);
        send_touch(900, 1023, 512, 512);
        send_touch(1023, 900, 512, 512);
        send_touch(901, 901, 0, 0);
        send_touch(1023, 1023, 30, 30);
        send_touch(1023, 1023, 80, 80);
        send_touch(1023, 1023, 131, 80);
        send_touch(1023, 1023, 131, 132);
        send_touch(1023, 1023, 1023, 1023);
        send_touch(1023, 1023, 1023, 1023);
        send_touch(1023, 1023, 1000, 1023);
        send_touch(1023, 1023, 1000, 1000);
        send_touch(1023, 1023, 1015, 1000);
        send_touch(512, 1023, 1023, 0);
        send_touch(1023, 1023, 1000, 0);
        send_touch(1023, 1023, 1000, 0);
        finish_phase();

        for (int phase = 0; phase < PHASES; phase++) begin
            choose_settings(phase);
            program_registers();
            calm = (phase == CALM_PHASE);
            if (phase == SQUEEZE_PHASE)
                squeeze = 1'b1;
            repeat (PHASE_ITEMS) random_touch();
            finish_phase();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("** touch_sample_calibrate_scale: PASSED **");
        end else begin
            $display("** touch_sample_calibrate_scale: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/tscs_pkg.sv
hdl/tscs_regs.sv
hdl/tscs_div.sv
hdl/touch_sample_calibrate_scale.sv
bench/touch_sample_checker.sv
bench/touch_sample_calibrate_scale_test.sv
